// ----- rtl/dbo_pkg.sv -----
// ----------------------------------------------------------------------------
// Detection box overlay package
// Shared types, codes and small functions for the box overlay block.
// ----------------------------------------------------------------------------
package dbo_pkg;

  // Action codes carried by an input transaction.
  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THICK  = 2'd2
  } reg_idx_e;

  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [3:0]  THICK_RST  = 4'd2;
  localparam logic [12:0] DIM_LIMIT  = 13'd4096;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [3:0]  thick;
  } cfg_t;

  // One clamped box with its palette index.
  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic [2:0]  col;
  } box_t;

  // Transaction as it travels along the chain of cells.
  typedef struct packed {
    action_e     action;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        in_img;
    box_t        box;
    logic        hit;
    logic [2:0]  col;
  } item_t;

  // Clamp a signed corner into [0, min(size, 4096) - 1]; a size of zero gives 0.
  function automatic logic [11:0] clamp_dim(input logic signed [15:0] v,
                                            input logic [12:0] size);
    logic [12:0] lim;
    logic [12:0] hi;
    begin
      lim = (size > DIM_LIMIT) ? DIM_LIMIT : size;
      hi  = lim - 13'd1;
      if (v[15] || (size == 13'd0)) begin
        return 12'd0;
      end else if ({1'b0, v[14:0]} > {3'b000, hi}) begin
        return hi[11:0];
      end else begin
        return v[11:0];
      end
    end
  endfunction

  // Fixed eight-entry color palette, returned as {red, green, blue}.
  function automatic logic [23:0] palette(input logic [2:0] idx);
    logic [23:0] c;
    begin
      unique case (idx)
        3'd0:    c = {8'd255, 8'd64,  8'd64};
        3'd1:    c = {8'd64,  8'd255, 8'd64};
        3'd2:    c = {8'd64,  8'd64,  8'd255};
        3'd3:    c = {8'd255, 8'd255, 8'd0};
        3'd4:    c = {8'd255, 8'd0,   8'd255};
        3'd5:    c = {8'd0,   8'd255, 8'd255};
        3'd6:    c = {8'd255, 8'd128, 8'd0};
        default: c = {8'd128, 8'd0,   8'd255};
      endcase
      return c;
    end
  endfunction

endpackage

// ----- rtl/dbo_stream_if.sv -----
// ----------------------------------------------------------------------------
// Detection box overlay stream interfaces
// Valid/ready channels for input transactions and result pixels.
// ----------------------------------------------------------------------------

// Input channel: pixel, add-box and clear transactions.
interface dbo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [15:0] box_left;
  logic [15:0] box_top;
  logic [15:0] box_right;
  logic [15:0] box_bottom;
  logic [7:0]  box_class;

  modport source (
    output valid, action, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           box_left, box_top, box_right, box_bottom, box_class,
    input  ready
  );
  modport sink (
    input  valid, action, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           box_left, box_top, box_right, box_bottom, box_class,
    output ready
  );
endinterface

// Output channel: one result per pixel transaction.
interface dbo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       on_outline;

  modport source (
    output valid, out_red, out_green, out_blue, on_outline,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, on_outline,
    output ready
  );
endinterface

// ----- rtl/dbo_cfg.sv -----
// ----------------------------------------------------------------------------
// Detection box overlay configuration registers
// APB-style register file for image size and outline thickness.
// ----------------------------------------------------------------------------
module dbo_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dbo_pkg::cfg_t      cfg_o
);

  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [3:0]  thick_q;
  logic        wr_en;
  dbo_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dbo_pkg::reg_idx_e'(paddr[3:2]);

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dbo_pkg::WIDTH_RST;
      height_q <= dbo_pkg::HEIGHT_RST;
      thick_q  <= dbo_pkg::THICK_RST;
    end else if (wr_en) begin
      unique case (idx)
        dbo_pkg::REG_WIDTH:  width_q  <= pwdata[12:0];
        dbo_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
        dbo_pkg::REG_THICK:  thick_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      dbo_pkg::REG_WIDTH:  prdata = {19'd0, width_q};
      dbo_pkg::REG_HEIGHT: prdata = {19'd0, height_q};
      dbo_pkg::REG_THICK:  prdata = {28'd0, thick_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.thick  = thick_q;

endmodule

// ----- rtl/dbo_cell.sv -----
// ----------------------------------------------------------------------------
// Detection box overlay cell
// Holds one box slot, tests passing pixels against it and hands on.
// ----------------------------------------------------------------------------
module dbo_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [3:0]          thick_i,
  input  logic                valid_i,
  input  dbo_pkg::item_t      item_i,
  input  logic [CNT_W-1:0]    cnt_i,
  output logic                valid_o,
  output dbo_pkg::item_t      item_o,
  output logic [CNT_W-1:0]    cnt_o
);

  localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

  dbo_pkg::box_t   box_q;
  dbo_pkg::item_t  item_d;
  dbo_pkg::item_t  item_q;
  logic [CNT_W-1:0] cnt_q;
  logic            valid_q;
  logic            x_in;
  logic            y_in;
  logic            on_box;

  // True when a - b lies in [0, t).
  function automatic logic band(input logic [11:0] a, input logic [11:0] b,
                                input logic [3:0] t);
    logic [11:0] d;
    begin
      d = a - b;
      return (a >= b) && (d < {8'd0, t});
    end
  endfunction

  // Outline test against the stored box.
  always_comb begin
    x_in   = (item_i.x >= box_q.left) && (item_i.x <= box_q.right);
    y_in   = (item_i.y >= box_q.top) && (item_i.y <= box_q.bottom);
    on_box = (x_in && (band(item_i.y, box_q.top, thick_i) ||
                       band(box_q.bottom, item_i.y, thick_i))) ||
             (y_in && (band(item_i.x, box_q.left, thick_i) ||
                       band(box_q.right, item_i.x, thick_i)));
  end

  // A later slot overrides any hit found in an earlier one.
  always_comb begin
    item_d = item_i;
    if ((item_i.action == dbo_pkg::ACT_PIXEL) && item_i.in_img &&
        (SLOT < cnt_i) && on_box) begin
      item_d.hit = 1'b1;
      item_d.col = box_q.col;
    end
  end

  // Box slot is written when the add transaction for this slot passes.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i && (item_i.action == dbo_pkg::ACT_ADD) &&
        (cnt_i == SLOT)) begin
      box_q <= item_i.box;
    end
  end

  // Hand-off registers to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
      cnt_q  <= cnt_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign cnt_o   = cnt_q;

endmodule

// ----- rtl/detection_box_overlay_top.sv -----
// ----------------------------------------------------------------------------
// Detection box overlay top level
// Draws box outlines over a pixel stream with a chain of box cells.
// ----------------------------------------------------------------------------
// Usage: transactions enter on in_i (valid/ready). A pixel transaction gives
// one result on out_o; add-box and clear transactions give none. Boxes are
// clamped to the image on entry and each cell of the chain holds one box slot.
// Every transaction walks the chain one cell per cycle unless the chain holds, so
// a pixel sees just the boxes that were in the list when it was accepted, and
// the newest box whose outline covers it sets its color.
// Path: a pixel's result passes every cell register, then the output register.
// Throughput: one transaction per cycle, set by the chain, while it does not hold.
// Reset empties the chain and the box list and loads the register defaults
// (width 640, height 480, thickness 2); no clearing pass is needed.
// When the receiver stalls, the result waits in the output register; the chain
// keeps moving as long as no second result is about to reach it, and then
// the whole chain holds and in_i.ready drops.
// Registers over APB: 0x0 width, 0x4 height, 0x8 thickness; write them idle.
// ----------------------------------------------------------------------------
module detection_box_overlay_top #(
  parameter int unsigned MAX_BOXES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbo_in_if.sink      in_i,
  dbo_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

  dbo_pkg::cfg_t   cfg;
  dbo_pkg::item_t  item_w [MAX_BOXES+1];
  logic [CNT_W-1:0] cnt_w [MAX_BOXES+1];
  logic            valid_w [MAX_BOXES+1];
  logic [CNT_W-1:0] count_q;
  logic            adv;
  logic            accept;
  logic            last_pix;
  logic            out_valid_q;
  logic [7:0]      red_q;
  logic [7:0]      green_q;
  logic [7:0]      blue_q;
  logic            hit_q;
  logic [23:0]     pal;
  dbo_pkg::action_e act;

  dbo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Chain moves unless a result would collide with one still waiting.
  assign last_pix = valid_w[MAX_BOXES] &&
                    (item_w[MAX_BOXES].action == dbo_pkg::ACT_PIXEL);
  assign adv      = !(out_valid_q && !out_o.ready && last_pix);
  assign in_i.ready = adv;
  assign accept   = in_i.valid && adv;
  assign act      = dbo_pkg::action_e'(in_i.action);

  // Box count: a clear empties the list, an add takes the next free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      if (act == dbo_pkg::ACT_CLEAR) begin
        count_q <= '0;
      end else if ((act == dbo_pkg::ACT_ADD) && (count_q < CNT_MAX)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Entry of the chain: clamp corners and flag pixels inside the image.
  always_comb begin
    item_w[0].action     = act;
    item_w[0].x          = in_i.pixel_x;
    item_w[0].y          = in_i.pixel_y;
    item_w[0].red        = in_i.pixel_red;
    item_w[0].green      = in_i.pixel_green;
    item_w[0].blue       = in_i.pixel_blue;
    item_w[0].in_img     = ({1'b0, in_i.pixel_x} < cfg.width) &&
                           ({1'b0, in_i.pixel_y} < cfg.height);
    item_w[0].box.left   = dbo_pkg::clamp_dim(in_i.box_left, cfg.width);
    item_w[0].box.top    = dbo_pkg::clamp_dim(in_i.box_top, cfg.height);
    item_w[0].box.right  = dbo_pkg::clamp_dim(in_i.box_right, cfg.width);
    item_w[0].box.bottom = dbo_pkg::clamp_dim(in_i.box_bottom, cfg.height);
    item_w[0].box.col    = in_i.box_class[2:0];
    item_w[0].hit        = 1'b0;
    item_w[0].col        = 3'd0;
  end

  assign valid_w[0] = in_i.valid;
  assign cnt_w[0]   = count_q;

  // Row of box cells, slot i in cell i.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    dbo_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .thick_i (cfg.thick),
      .valid_i (valid_w[i]),
      .item_i  (item_w[i]),
      .cnt_i   (cnt_w[i]),
      .valid_o (valid_w[i+1]),
      .item_o  (item_w[i+1]),
      .cnt_o   (cnt_w[i+1])
    );
  end

  assign pal = dbo_pkg::palette(item_w[MAX_BOXES].col);

  // Output register: loads a finished pixel, clears when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_pix) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_pix) begin
      hit_q <= item_w[MAX_BOXES].hit;
      if (item_w[MAX_BOXES].hit) begin
        red_q   <= pal[23:16];
        green_q <= pal[15:8];
        blue_q  <= pal[7:0];
      end else begin
        red_q   <= item_w[MAX_BOXES].red;
        green_q <= item_w[MAX_BOXES].green;
        blue_q  <= item_w[MAX_BOXES].blue;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_red    = red_q;
  assign out_o.out_green  = green_q;
  assign out_o.out_blue   = blue_q;
  assign out_o.on_outline = hit_q;

endmodule

// ----- tb/sv/dbo_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box overlay test package
// Transaction types and the scoreboard that predicts and checks result pixels.
// ----------------------------------------------------------------------------
package dbo_tb_pkg;

  localparam int unsigned BOX_SLOTS  = 16;
  // Action code the block must ignore.
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  // One input transaction with every field of the input channel.
  typedef struct {
    logic [1:0]         action;
    logic [11:0]        px;
    logic [11:0]        py;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [7:0]         cls;
  } overlay_req_t;

  // One result pixel.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outline;
  } overlay_pix_t;

  // Limit a signed corner to the image; sizes above 4096 count as 4096.
  function automatic logic [11:0] clamp_corner(logic signed [15:0] v, logic [12:0] size);
    int hi;
    int c;
    hi = ((size > 13'd4096) ? 4096 : int'(size)) - 1;
    c  = int'(v);
    if (c > hi) c = hi;
    if (c < 0) c = 0;
    return c[11:0];
  endfunction

  // Outline color for a palette index, as {red, green, blue}.
  function automatic logic [23:0] class_color(logic [2:0] idx);
    logic [23:0] colors [8];
    colors = '{24'hFF4040, 24'h40FF40, 24'h4040FF, 24'hFFFF00,
               24'hFF00FF, 24'h00FFFF, 24'hFF8000, 24'h8000FF};
    return colors[idx];
  endfunction

  // True when the pixel lies in an edge band along the left, right, top or bottom side of the box.
  function automatic bit box_covers(dbo_pkg::box_t bx, int x, int y, int t);
    int l, tp, r, b;
    l  = int'(bx.left);
    tp = int'(bx.top);
    r  = int'(bx.right);
    b  = int'(bx.bottom);
    if (x >= l && x <= r &&
        ((y - tp >= 0 && y - tp < t) || (b - y >= 0 && b - y < t)))
      return 1'b1;
    if (y >= tp && y <= b &&
        ((x - l >= 0 && x - l < t) || (r - x >= 0 && r - x < t)))
      return 1'b1;
    return 1'b0;
  endfunction

  class overlay_scoreboard;
    logic [12:0]   img_w;
    logic [12:0]   img_h;
    logic [3:0]    thick;
    dbo_pkg::box_t boxes [BOX_SLOTS];
    int unsigned   n_boxes;
    overlay_pix_t  expected_q [$];
    int unsigned   err_count;
    int unsigned   result_count;

    function new();
      img_w        = dbo_pkg::WIDTH_RST;
      img_h        = dbo_pkg::HEIGHT_RST;
      thick        = dbo_pkg::THICK_RST;
      n_boxes      = 0;
      err_count    = 0;
      result_count = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      err_count++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_reg(dbo_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        dbo_pkg::REG_WIDTH:  img_w = value[12:0];
        dbo_pkg::REG_HEIGHT: img_h = value[12:0];
        dbo_pkg::REG_THICK:  thick = value[3:0];
        default: ;
      endcase
    endfunction

    // Update the box list for an accepted transaction and queue the pixel it yields.
    function void note_input(overlay_req_t it);
      overlay_pix_t px;
      logic [23:0]  c;
      int           i;
      case (it.action)
        dbo_pkg::ACT_CLEAR: n_boxes = 0;
        dbo_pkg::ACT_ADD: begin
          if (n_boxes < BOX_SLOTS) begin
            boxes[n_boxes].left   = clamp_corner(it.left, img_w);
            boxes[n_boxes].top    = clamp_corner(it.top, img_h);
            boxes[n_boxes].right  = clamp_corner(it.right, img_w);
            boxes[n_boxes].bottom = clamp_corner(it.bottom, img_h);
            boxes[n_boxes].col    = it.cls[2:0];
            n_boxes++;
          end
        end
        dbo_pkg::ACT_PIXEL: begin
          px = '{red: it.red, green: it.green, blue: it.blue, outline: 1'b0};
          if ({1'b0, it.px} < img_w && {1'b0, it.py} < img_h) begin
            // The newest box whose outline covers the pixel decides the color.
            for (i = int'(n_boxes) - 1; i >= 0; i--) begin
              if (box_covers(boxes[i], int'(it.px), int'(it.py), int'(thick))) begin
                c = class_color(boxes[i].col);
                px = '{red: c[23:16], green: c[15:8], blue: c[7:0], outline: 1'b1};
                break;
              end
            end
          end
          expected_q.push_back(px);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                               logic outline);
      overlay_pix_t ex;
      result_count++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no pixel pending", result_count));
        return;
      end
      ex = expected_q.pop_front();
      if (red !== ex.red)
        report($sformatf("result %0d red %0d, want %0d", result_count, red, ex.red));
      if (green !== ex.green)
        report($sformatf("result %0d green %0d, want %0d", result_count, green, ex.green));
      if (blue !== ex.blue)
        report($sformatf("result %0d blue %0d, want %0d", result_count, blue, ex.blue));
      if (outline !== ex.outline)
        report($sformatf("result %0d on_outline %0b, want %0b", result_count, outline,
                         ex.outline));
    endfunction
  endclass

endpackage

// ----- tb/sv/detection_box_overlay_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box overlay testbench
// Streams clear, add-box and pixel transactions through the block under random
// source gaps and sink stalls, over several register settings, and checks
// every result pixel against a scoreboard that tracks the box list.
// ----------------------------------------------------------------------------
module detection_box_overlay_top_tb;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = dbo_tb_pkg::BOX_SLOTS + 8;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SLOTS        = dbo_tb_pkg::BOX_SLOTS;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dbo_in_if  in_bus ();
  dbo_out_if out_bus ();

  detection_box_overlay_top #(
    .MAX_BOXES (SLOTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dbo_tb_pkg::overlay_scoreboard sb = new();

  // Traffic shaping shared between the processes.
  bit          send_burst = 1'b0;
  bit          sink_burst = 1'b0;
  bit          stall_req  = 1'b0;
  int unsigned cycle_count = 0;

  // Current image setting, used to aim boxes and pixels.
  int cur_wx = 640;
  int cur_hx = 480;
  int cur_t  = 2;

  // Clipped corners of the boxes the block currently holds.
  int tgt_l [SLOTS];
  int tgt_t [SLOTS];
  int tgt_r [SLOTS];
  int tgt_b [SLOTS];
  int n_tgt = 0;

  always #6 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one transaction after a random gap and hold it until accepted.
  task automatic drive_item(dbo_tb_pkg::overlay_req_t it);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= it.action;
    in_bus.pixel_x     <= it.px;
    in_bus.pixel_y     <= it.py;
    in_bus.pixel_red   <= it.red;
    in_bus.pixel_green <= it.green;
    in_bus.pixel_blue  <= it.blue;
    in_bus.box_left    <= it.left;
    in_bus.box_top     <= it.top;
    in_bus.box_right   <= it.right;
    in_bus.box_bottom  <= it.bottom;
    in_bus.box_class   <= it.cls;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  // Write a register, then read it back.
  task automatic program_reg(dbo_pkg::reg_idx_e idx, logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    want = (idx == dbo_pkg::REG_THICK) ? (value & 32'hF) : (value & 32'h1FFF);
    if (prdata !== want)
      sb.report($sformatf("register %s reads %0h, want %0h", idx.name(), prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Let every pending pixel come out and the chain empty behind it.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_image(int unsigned w, int unsigned h, int unsigned t);
    program_reg(dbo_pkg::REG_WIDTH, w);
    program_reg(dbo_pkg::REG_HEIGHT, h);
    program_reg(dbo_pkg::REG_THICK, t);
    cur_wx = (w == 0) ? 1 : ((w > 4096) ? 4096 : int'(w));
    cur_hx = (h == 0) ? 1 : ((h > 4096) ? 4096 : int'(h));
    cur_t  = t;
  endtask

  // Every field random, any action; the base of all transactions.
  function automatic dbo_tb_pkg::overlay_req_t random_req();
    dbo_tb_pkg::overlay_req_t it;
    it.action = 2'($urandom_range(0, 3));
    it.px     = 12'($urandom_range(0, 4095));
    it.py     = 12'($urandom_range(0, 4095));
    it.red    = 8'($urandom_range(0, 255));
    it.green  = 8'($urandom_range(0, 255));
    it.blue   = 8'($urandom_range(0, 255));
    it.left   = 16'($urandom_range(0, 65535));
    it.top    = 16'($urandom_range(0, 65535));
    it.right  = 16'($urandom_range(0, 65535));
    it.bottom = 16'($urandom_range(0, 65535));
    it.cls    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic int clip(int v, int size);
    if (v < 0) return 0;
    if (v > size - 1) return size - 1;
    return v;
  endfunction

  task automatic send_clear();
    dbo_tb_pkg::overlay_req_t it;
    it = random_req();
    it.action = dbo_pkg::ACT_CLEAR;
    n_tgt = 0;
    drive_item(it);
  endtask

  task automatic add_box(int l, int t, int r, int b, logic [7:0] cls);
    dbo_tb_pkg::overlay_req_t it;
    it = random_req();
    it.action = dbo_pkg::ACT_ADD;
    it.left   = l[15:0];
    it.top    = t[15:0];
    it.right  = r[15:0];
    it.bottom = b[15:0];
    it.cls    = cls;
    if (n_tgt < SLOTS) begin
      tgt_l[n_tgt] = clip(l, cur_wx);
      tgt_t[n_tgt] = clip(t, cur_hx);
      tgt_r[n_tgt] = clip(r, cur_wx);
      tgt_b[n_tgt] = clip(b, cur_hx);
      n_tgt++;
    end
    drive_item(it);
  endtask

  task automatic send_pixel(int x, int y);
    dbo_tb_pkg::overlay_req_t it;
    it = random_req();
    it.action = dbo_pkg::ACT_PIXEL;
    it.px     = x[11:0];
    it.py     = y[11:0];
    drive_item(it);
  endtask

  // Mostly boxes inside the image, some with wild corners, some inverted.
  task automatic gen_box();
    int l, t, r, b, sel;
    sel = $urandom_range(0, 9);
    l = int'($urandom_range(0, cur_wx + 5)) - 3;
    t = int'($urandom_range(0, cur_hx + 5)) - 3;
    r = l + int'($urandom_range(0, cur_wx / 2 + 2));
    b = t + int'($urandom_range(0, cur_hx / 2 + 2));
    if (sel == 7) begin
      r = l - int'($urandom_range(1, 8));
      b = t - int'($urandom_range(1, 8));
    end else if (sel >= 8) begin
      l = int'($urandom_range(0, 65535)) - 32768;
      t = int'($urandom_range(0, 65535)) - 32768;
      r = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
    end
    add_box(l, t, r, b, 8'($urandom_range(0, 255)));
  endtask

  // Pixels aimed at the edge bands of a held box, with some scattered ones.
  task automatic gen_pixel();
    int x, y, k, off;
    if (n_tgt != 0 && $urandom_range(0, 3) != 0) begin
      k   = $urandom_range(0, n_tgt - 1);
      off = int'($urandom_range(0, cur_t + 2)) - 1;
      case ($urandom_range(0, 3))
        0: begin
          x = tgt_l[k] + off;
          y = $urandom_range(tgt_t[k], tgt_b[k]);
        end
        1: begin
          x = tgt_r[k] - off;
          y = $urandom_range(tgt_t[k], tgt_b[k]);
        end
        2: begin
          y = tgt_t[k] + off;
          x = $urandom_range(tgt_l[k], tgt_r[k]);
        end
        default: begin
          y = tgt_b[k] - off;
          x = $urandom_range(tgt_l[k], tgt_r[k]);
        end
      endcase
    end else if ($urandom_range(0, 9) == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end else begin
      x = $urandom_range(0, cur_wx);
      y = $urandom_range(0, cur_hx);
    end
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    send_pixel(x, y);
  endtask

  // Clear, fill the list, then paint pixels; a little noise mixed in.
  task automatic run_sequences(int budget);
    int sent, n_add, n_pix, k;
    sent = 0;
    while (sent < budget) begin
      send_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) begin
        send_clear();
        sent++;
      end
      n_add = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
      for (k = 0; k < n_add; k++) begin
        gen_box();
        sent++;
      end
      n_pix = $urandom_range(6, 24);
      for (k = 0; k < n_pix; k++) begin
        if ($urandom_range(0, 19) == 0) drive_item(random_req());
        else gen_pixel();
        sent++;
      end
    end
    send_burst = 1'b0;
  endtask

  // Result side: random stalls, bursts, and one long hold on request.
  initial begin : result_sink
    int unsigned hold;
    out_bus.ready <= 1'b0;
    @(negedge clk_i);
    forever begin
      if (stall_req) begin
        hold = LONG_HOLD;
        stall_req = 1'b0;
      end else begin
        hold = sink_burst ? 0 : $urandom_range(0, 17);
      end
      if (hold != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      sb.check_result(out_bus.out_red, out_bus.out_green, out_bus.out_blue,
                      out_bus.on_outline);
      if ($urandom_range(0, 39) == 0) sink_burst = ~sink_burst;
      @(negedge clk_i);
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int unsigned edge_w [4];
    int unsigned edge_h [4];
    int unsigned edge_t [4];
    int          p;
    edge_w = '{4096, 1, 8191, 0};
    edge_h = '{4096, 1, 8191, 0};
    edge_t = '{15, 0, 1, 3};

    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= dbo_pkg::ACT_PIXEL;
    in_bus.pixel_x     <= '0;
    in_bus.pixel_y     <= '0;
    in_bus.pixel_red   <= '0;
    in_bus.pixel_green <= '0;
    in_bus.pixel_blue  <= '0;
    in_bus.box_left    <= '0;
    in_bus.box_top     <= '0;
    in_bus.box_right   <= '0;
    in_bus.box_bottom  <= '0;
    in_bus.box_class   <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset setting (640 x 480, thickness 2).
    send_pixel(0, 0);
    // Corners far outside the image clamp to its border; class 255 picks color 7.
    add_box(-32768, -5, 32767, 700, 8'hFF);
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(1, 1);
    send_pixel(2, 2);
    send_pixel(640, 10);
    send_pixel(10, 480);
    send_pixel(4095, 4095);
    // Inverted box.
    add_box(100, 10, 50, 200, 8'h00);
    send_pixel(50, 100);
    send_pixel(100, 100);
    add_box(20, 20, 30, 30, 8'h03);
    send_pixel(25, 20);
    send_pixel(25, 25);
    send_pixel(0, 25);
    // A small newer box; pixel (5, 5) lies on its outline only.
    add_box(5, 5, 6, 6, 8'h0C);
    send_pixel(5, 5);
    send_clear();
    send_pixel(0, 0);
    begin : unused_action
      dbo_tb_pkg::overlay_req_t it;
      it = random_req();
      it.action = dbo_tb_pkg::ACT_UNUSED;
      drive_item(it);
    end
    drain();

    // Extreme settings: largest image, one pixel, oversize values, zero size.
    for (p = 0; p < 4; p++) begin
      set_image(edge_w[p], edge_h[p], edge_t[p]);
      run_sequences((edge_w[p] == 0) ? 20 : 40);
      drain();
    end

    // Random settings, mostly small images so boxes are dense.
    for (p = 0; p < 6; p++) begin
      if (p == 5) set_image($urandom_range(1000, 4096), $urandom_range(1000, 4096),
                            $urandom_range(0, 15));
      else set_image($urandom_range(8, 160), $urandom_range(8, 120), $urandom_range(0, 15));
      run_sequences(50);
      if (p == 2) begin : back_pressure
        int k;
        // The sink holds off while pixels keep coming, so the chain fills.
        send_burst = 1'b1;
        stall_req  = 1'b1;
        for (k = 0; k < 60; k++) gen_pixel();
        send_burst = 1'b0;
      end
      drain();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d result pixels never arrived", sb.pending()));
    if (sb.err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
